/* hdl/tls_pkg.sv */
// ----------------------------------------------------------------------------
// tls_pkg: shared types and constants of the text line segmenter
// Register codes, default sizes, the group control struct passed from the
// lane stage to the merge stage, and the line box carried to the output.
// ----------------------------------------------------------------------------
package tls_pkg;

   // default sizing of the top level
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int LANES_DEF      = 8;

   // fixed field widths
   localparam int CFG_W       = 13;
   localparam int COORD_W     = 12;
   localparam int CSR_INDEX_W = 2;

   // register reset values
   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd1024;

   // result queue sizing
   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // per-group control from the lane stage
   typedef struct packed {
      logic valid;
      logic row_end;
      logic frame_end;
   } grp_ctl_type;

   // bounding box of one text line
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic               at_frame_end;
   } box_type;

endpackage

/* hdl/text_line_segmenter_top.sv */
// ----------------------------------------------------------------------------
// text_line_segmenter_top: projection-profile text line segmenter
// Takes a binary image in raster order, LANES pixels per item, and emits the
// inclusive bounding box of every maximal run of inked rows.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_ready is high. An item is
// registered in the lane stage (one lane per pixel, plus the column/row
// counters) and in the next cycle passes the merge stage, which folds it
// into the row and line extents; a box closed by that item is stored in the
// result queue and shows on rsp_valid from there. Boxes wait in a
// three-entry queue; req_ready drops only while that queue plus the item in
// the lane stage would fill it, that is when results are not being taken.
// A box is emitted
// at the end of the first blank row after a line, or at the end of the
// frame's last row if the line is still open; image_width and image_height
// of 0 act as 1 and values above MAX_WIDTH / MAX_HEIGHT are clamped. Write
// the size registers only while the block is idle.
module text_line_segmenter_top #(
   parameter int MAX_WIDTH  = tls_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tls_pkg::MAX_HEIGHT_DEF,
   parameter int LANES      = tls_pkg::LANES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [LANES-1:0]                  req_ink_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tls_pkg::COORD_W-1:0]       rsp_left,
   output logic [tls_pkg::COORD_W-1:0]       rsp_top,
   output logic [tls_pkg::COORD_W-1:0]       rsp_right,
   output logic [tls_pkg::COORD_W-1:0]       rsp_bottom,
   output logic                              rsp_at_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tls_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tls_pkg::CFG_W-1:0]         csr_data
);

   localparam int WSW = ($clog2(MAX_WIDTH + 1) > tls_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : tls_pkg::CFG_W;
   localparam int HSW = ($clog2(MAX_HEIGHT + 1) > tls_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : tls_pkg::CFG_W;
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PDW = tls_pkg::RSP_CNT_W + 1;

   logic [tls_pkg::CFG_W-1:0] image_width_ff, image_width_in;
   logic [tls_pkg::CFG_W-1:0] image_height_ff, image_height_in;
   logic [WSW-1:0]            width_raw, width_lim;
   logic [HSW-1:0]            height_raw, height_lim;

   logic                          in_accept;
   tls_pkg::grp_ctl_type          grp_ctl;
   logic [LANES-1:0]              grp_mask;
   logic [CW-1:0]                 grp_col;
   logic [RW-1:0]                 grp_row;
   logic                          push;
   tls_pkg::box_type              push_box;
   tls_pkg::box_type              out_box;
   logic [tls_pkg::RSP_CNT_W-1:0] fill;
   logic [PDW-1:0]                pending;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tls_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_data;
            tls_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= tls_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= tls_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // effective sizes: zero acts as one, clamp to the maximum
   assign width_raw  = WSW'(image_width_ff);
   assign height_raw = HSW'(image_height_ff);

   always_comb begin
      priority if (width_raw == '0) width_lim = WSW'(1);
      else if (width_raw > WSW'(MAX_WIDTH)) width_lim = WSW'(MAX_WIDTH);
      else width_lim = width_raw;
   end

   always_comb begin
      priority if (height_raw == '0) height_lim = HSW'(1);
      else if (height_raw > HSW'(MAX_HEIGHT)) height_lim = HSW'(MAX_HEIGHT);
      else height_lim = height_raw;
   end

   // hold input off when queued results plus the item in flight fill the queue
   assign pending   = PDW'(fill) + PDW'(grp_ctl.valid);
   assign req_ready = pending < PDW'(tls_pkg::RSP_DEPTH);
   assign in_accept = req_valid && req_ready;

   tls_lanes #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LANES      (LANES)
   ) u_lanes (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .ink_bits   (req_ink_bits),
      .width_lim  (width_lim),
      .height_lim (height_lim),
      .grp_ctl    (grp_ctl),
      .grp_mask   (grp_mask),
      .grp_col    (grp_col),
      .grp_row    (grp_row)
   );

   tls_merge #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LANES      (LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .grp_ctl  (grp_ctl),
      .grp_mask (grp_mask),
      .grp_col  (grp_col),
      .grp_row  (grp_row),
      .push     (push),
      .push_box (push_box)
   );

   tls_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_box  (push_box),
      .pop       (rsp_valid && rsp_ready),
      .out_valid (rsp_valid),
      .out_box   (out_box),
      .fill      (fill)
   );

   assign rsp_left         = out_box.left;
   assign rsp_top          = out_box.top;
   assign rsp_right        = out_box.right;
   assign rsp_bottom       = out_box.bottom;
   assign rsp_at_frame_end = out_box.at_frame_end;

endmodule

/* hdl/tls_lanes.sv */
// ----------------------------------------------------------------------------
// tls_lanes: pixel lanes and raster position
// Each lane qualifies one pixel of the group against the row width. The
// column and row counters advance per item and flag end of row and frame.
// ----------------------------------------------------------------------------
module tls_lanes #(
   parameter int MAX_WIDTH  = tls_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tls_pkg::MAX_HEIGHT_DEF,
   parameter int LANES      = tls_pkg::LANES_DEF,
   localparam int WSW = ($clog2(MAX_WIDTH + 1) > tls_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : tls_pkg::CFG_W,
   localparam int HSW = ($clog2(MAX_HEIGHT + 1) > tls_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : tls_pkg::CFG_W,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [LANES-1:0]      ink_bits,
   input  logic [WSW-1:0]        width_lim,
   input  logic [HSW-1:0]        height_lim,
   output tls_pkg::grp_ctl_type  grp_ctl,
   output logic [LANES-1:0]      grp_mask,
   output logic [CW-1:0]         grp_col,
   output logic [RW-1:0]         grp_row
);

   localparam int LPW  = $clog2(LANES + 1);
   localparam int SUMW = WSW + LPW;
   localparam int RSW  = HSW + 1;

   logic [CW-1:0]        col_pos_ff, col_pos_in;
   logic [RW-1:0]        row_pos_ff, row_pos_in;
   tls_pkg::grp_ctl_type ctl_ff, ctl_in;
   logic [LANES-1:0]     mask_ff;
   logic [CW-1:0]        col_ff;
   logic [RW-1:0]        row_ff;

   logic [LANES-1:0]     lane_ok;
   logic [LANES-1:0]     mask_in;
   logic                 row_end;
   logic                 frame_end;
   logic [RSW-1:0]       row_inc;

   // one lane per pixel: inside the row and inked
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign lane_ok[i] = (SUMW'(col_pos_ff) + SUMW'(i)) < SUMW'(width_lim);
      assign mask_in[i] = ink_bits[i] & lane_ok[i];
   end

   // end of row once the group reaches or passes the width
   assign row_end   = (SUMW'(col_pos_ff) + SUMW'(LANES)) >= SUMW'(width_lim);
   assign row_inc   = RSW'(row_pos_ff) + RSW'(1);
   assign frame_end = row_end && (row_inc >= RSW'(height_lim));

   // raster position update
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (in_accept) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = frame_end ? '0 : (row_pos_ff + RW'(1));
         end else begin
            col_pos_in = col_pos_ff + CW'(LANES);
         end
      end
   end

   // stage control
   always_comb begin
      ctl_in           = ctl_ff;
      ctl_in.valid     = in_accept;
      if (in_accept) begin
         ctl_in.row_end   = row_end;
         ctl_in.frame_end = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         ctl_ff     <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         ctl_ff     <= ctl_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_accept) begin
         mask_ff <= mask_in;
         col_ff  <= col_pos_ff;
         row_ff  <= row_pos_ff;
      end
   end

   assign grp_ctl  = ctl_ff;
   assign grp_mask = mask_ff;
   assign grp_col  = col_ff;
   assign grp_row  = row_ff;

endmodule

/* hdl/tls_merge.sv */
// ----------------------------------------------------------------------------
// tls_merge: lane merge and line tracking
// Finds the first and last inked lane of a group, folds them into the row
// extent, and at row end extends, opens or closes the current text line.
// ----------------------------------------------------------------------------
module tls_merge #(
   parameter int MAX_WIDTH  = tls_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tls_pkg::MAX_HEIGHT_DEF,
   parameter int LANES      = tls_pkg::LANES_DEF,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tls_pkg::grp_ctl_type  grp_ctl,
   input  logic [LANES-1:0]      grp_mask,
   input  logic [CW-1:0]         grp_col,
   input  logic [RW-1:0]         grp_row,
   output logic                  push,
   output tls_pkg::box_type      push_box
);

   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

   logic          row_has_ff, row_has_in;
   logic [CW-1:0] row_first_ff, row_first_in;
   logic [CW-1:0] row_last_ff, row_last_in;
   logic          inside_ff, inside_in;
   logic [RW-1:0] line_row_ff, line_row_in;
   logic [CW-1:0] line_left_ff, line_left_in;
   logic [CW-1:0] line_right_ff, line_right_in;

   logic          any_ink;
   logic [LW-1:0] first_idx;
   logic [LW-1:0] last_idx;
   logic [CW-1:0] grp_first;
   logic [CW-1:0] grp_last;
   logic          eff_has;
   logic [CW-1:0] eff_first;
   logic [CW-1:0] eff_last;

   // low bits of a column or row as a result coordinate
   function automatic logic [tls_pkg::COORD_W-1:0] col_coord(input logic [CW-1:0] v);
      logic [CW+tls_pkg::COORD_W-1:0] t;
      t = {{tls_pkg::COORD_W{1'b0}}, v};
      return t[tls_pkg::COORD_W-1:0];
   endfunction

   function automatic logic [tls_pkg::COORD_W-1:0] row_coord(input logic [RW-1:0] v);
      logic [RW+tls_pkg::COORD_W-1:0] t;
      t = {{tls_pkg::COORD_W{1'b0}}, v};
      return t[tls_pkg::COORD_W-1:0];
   endfunction

   // first and last inked lane
   always_comb begin
      first_idx = '0;
      last_idx  = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (grp_mask[i]) first_idx = LW'(i);
      end
      for (int i = 0; i < LANES; i++) begin
         if (grp_mask[i]) last_idx = LW'(i);
      end
   end

   assign any_ink   = |grp_mask;
   assign grp_first = grp_col + CW'(first_idx);
   assign grp_last  = grp_col + CW'(last_idx);

   // row extent including this group
   assign eff_has   = row_has_ff | any_ink;
   assign eff_first = row_has_ff ? row_first_ff : grp_first;
   assign eff_last  = any_ink ? grp_last : row_last_ff;

   // row and line update, result on line close
   always_comb begin
      row_has_in    = row_has_ff;
      row_first_in  = row_first_ff;
      row_last_in   = row_last_ff;
      inside_in     = inside_ff;
      line_row_in   = line_row_ff;
      line_left_in  = line_left_ff;
      line_right_in = line_right_ff;
      push          = 1'b0;
      push_box      = '0;
      if (grp_ctl.valid) begin
         if (!grp_ctl.row_end) begin
            row_has_in   = eff_has;
            row_first_in = eff_first;
            row_last_in  = eff_last;
         end else begin
            row_has_in = 1'b0;
            if (eff_has) begin
               if (!inside_ff) begin
                  inside_in     = 1'b1;
                  line_row_in   = grp_row;
                  line_left_in  = eff_first;
                  line_right_in = eff_last;
               end else begin
                  if (eff_first < line_left_ff) line_left_in = eff_first;
                  if (eff_last > line_right_ff) line_right_in = eff_last;
               end
            end else if (inside_ff) begin
               // blank row closes the line
               push                  = 1'b1;
               push_box.left         = col_coord(line_left_ff);
               push_box.top          = row_coord(line_row_ff);
               push_box.right        = col_coord(line_right_ff);
               push_box.bottom       = row_coord(grp_row - RW'(1));
               push_box.at_frame_end = 1'b0;
               inside_in             = 1'b0;
            end
            if (grp_ctl.frame_end) begin
               // frame end closes a line still open
               if (inside_in) begin
                  push                  = 1'b1;
                  push_box.left         = col_coord(line_left_in);
                  push_box.top          = row_coord(line_row_in);
                  push_box.right        = col_coord(line_right_in);
                  push_box.bottom       = row_coord(grp_row);
                  push_box.at_frame_end = 1'b1;
               end
               inside_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_has_ff <= 1'b0;
         inside_ff  <= 1'b0;
      end else begin
         row_has_ff <= row_has_in;
         inside_ff  <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      row_first_ff  <= row_first_in;
      row_last_ff   <= row_last_in;
      line_row_ff   <= line_row_in;
      line_left_ff  <= line_left_in;
      line_right_ff <= line_right_in;
   end

endmodule

/* hdl/tls_rsp_queue.sv */
// ----------------------------------------------------------------------------
// tls_rsp_queue: result queue
// Small circular buffer of line boxes between the merge stage and the
// result channel, so the input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module tls_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  tls_pkg::box_type                push_box,
   input  logic                            pop,
   output logic                            out_valid,
   output tls_pkg::box_type                out_box,
   output logic [tls_pkg::RSP_CNT_W-1:0]   fill
);

   localparam int PW = tls_pkg::RSP_PTR_W;
   localparam int NW = tls_pkg::RSP_CNT_W;

   tls_pkg::box_type mem_ff [tls_pkg::RSP_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(tls_pkg::RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(tls_pkg::RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) count_in = count_ff + NW'(1);
      else if (pop && !push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_box;
   end

   assign out_valid = (count_ff != '0);
   assign out_box   = mem_ff[rd_ptr_ff];
   assign fill      = count_ff;

endmodule

/* hdl/tls_checker.sv */
// ----------------------------------------------------------------------------
// tls_checker: port-level checks of the text line segmenter
// Watches the result channel: held items, box ordering and reset behavior.
// ----------------------------------------------------------------------------
module tls_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tls_pkg::COORD_W-1:0]  rsp_left,
   input logic [tls_pkg::COORD_W-1:0]  rsp_top,
   input logic [tls_pkg::COORD_W-1:0]  rsp_right,
   input logic [tls_pkg::COORD_W-1:0]  rsp_bottom,
   input logic                         rsp_at_frame_end
);

   // a stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left) && $stable(rsp_top)
         && $stable(rsp_right) && $stable(rsp_bottom) && $stable(rsp_at_frame_end))
      else $error("result item changed while stalled");

   // a line box is never inverted
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left <= rsp_right) && (rsp_top <= rsp_bottom))
      else $error("line box inverted");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind text_line_segmenter_top tls_checker u_tls_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_left         (rsp_left),
   .rsp_top          (rsp_top),
   .rsp_right        (rsp_right),
   .rsp_bottom       (rsp_bottom),
   .rsp_at_frame_end (rsp_at_frame_end)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text line segmenter
// Streams binary image rows into the block in eight-pixel items and tracks
// the row and line extents in a software copy of the segmenter. Every line
// box that comes out is checked field by field against the oldest box that
// copy has queued. A short table of hand-written steps runs first. Random
// frames follow across several image sizes and handshake pacing modes,
// including one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LANE_COUNT      = tls_pkg::LANES_DEF;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PRESSURE_CYCLES = 400;
   localparam int RUN_LIMIT_NS    = 2000000;
   localparam int PHASES          = 6;

   // register indexes that map to nothing in the block
   localparam logic [tls_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [tls_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic [1:0] {
      STEP_CSR,
      STEP_PREDICT,
      STEP_BOX
   } step_kind_type;

   typedef struct packed {
      step_kind_type                   kind;
      logic [tls_pkg::CSR_INDEX_W-1:0] index;
      logic [tls_pkg::CFG_W-1:0]       data;
      logic [7:0]                      ink;
      tls_pkg::box_type                box;
   } plan_step_type;

   typedef enum logic [1:0] {
      ROW_BLANK,
      ROW_SPARSE,
      ROW_DENSE
   } row_style_type;

   // block ports
   logic                            clock;
   logic                            reset        = 1'b1;
   logic                            req_valid    = 1'b0;
   logic                            req_ready;
   logic [LANE_COUNT-1:0]           req_ink_bits = '0;
   logic                            rsp_valid;
   logic                            rsp_ready    = 1'b0;
   logic [tls_pkg::COORD_W-1:0]     rsp_left;
   logic [tls_pkg::COORD_W-1:0]     rsp_top;
   logic [tls_pkg::COORD_W-1:0]     rsp_right;
   logic [tls_pkg::COORD_W-1:0]     rsp_bottom;
   logic                            rsp_at_frame_end;
   logic                            csr_valid    = 1'b0;
   logic                            csr_ready;
   logic [tls_pkg::CSR_INDEX_W-1:0] csr_index    = '0;
   logic [tls_pkg::CFG_W-1:0]       csr_data     = '0;

   // pacing and pressure control
   int unsigned sender_idle_pct  = 0;
   int unsigned rsp_stall_pct    = 0;
   bit          pressure_req     = 1'b0;
   bit          pressure_done    = 1'b0;
   int unsigned hold_left        = 0;
   int unsigned error_count      = 0;

   // segmenter copy: registers and state
   logic [tls_pkg::CFG_W-1:0]   width_reg  = tls_pkg::IMAGE_WIDTH_RESET;
   logic [tls_pkg::CFG_W-1:0]   height_reg = tls_pkg::IMAGE_HEIGHT_RESET;
   int unsigned                 col_pos    = 0;
   int unsigned                 row_pos    = 0;
   bit                          row_inked  = 1'b0;
   logic [tls_pkg::COORD_W-1:0] row_left   = '0;
   logic [tls_pkg::COORD_W-1:0] row_right  = '0;
   bit                          in_line    = 1'b0;
   logic [tls_pkg::COORD_W-1:0] line_top   = '0;
   logic [tls_pkg::COORD_W-1:0] line_left  = '0;
   logic [tls_pkg::COORD_W-1:0] line_right = '0;

   tls_pkg::box_type line_box_q [$];
   plan_step_type    directed_plan [$];
   row_style_type    row_style = ROW_BLANK;

   // random phases: sizes, pacing, item counts
   int phase_width  [PHASES] = '{0, 20, 37, 8191, 12, 1};
   int phase_height [PHASES] = '{0, 5, 9, 8191, 3, 4096};
   int phase_idle   [PHASES] = '{0, 70, 0, 14, 14, 0};
   int phase_stall  [PHASES] = '{0, 0, 70, 14, 14, 0};
   int phase_items  [PHASES] = '{120, 150, 150, 530, 150, 100};

   text_line_segmenter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ink_bits     (req_ink_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left         (rsp_left),
      .rsp_top          (rsp_top),
      .rsp_right        (rsp_right),
      .rsp_bottom       (rsp_bottom),
      .rsp_at_frame_end (rsp_at_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic tls_pkg::box_type box_of(input logic [tls_pkg::COORD_W-1:0] left,
                                               input logic [tls_pkg::COORD_W-1:0] top,
                                               input logic [tls_pkg::COORD_W-1:0] right,
                                               input logic [tls_pkg::COORD_W-1:0] bottom,
                                               input logic at_end);
      tls_pkg::box_type b;
      b.left         = left;
      b.top          = top;
      b.right        = right;
      b.bottom       = bottom;
      b.at_frame_end = at_end;
      return b;
   endfunction

   // zero acts as one, oversize is clamped
   function automatic int unsigned size_in_use(input logic [tls_pkg::CFG_W-1:0] v,
                                               input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   // fold one item into the row and line extents; 1 when a line box closes
   function automatic bit fold_group(input logic [LANE_COUNT-1:0] ink,
                                     output tls_pkg::box_type box);
      int unsigned w;
      int unsigned h;
      int unsigned lanes_in;
      int unsigned i;
      bit          closed;
      w      = size_in_use(width_reg, tls_pkg::MAX_WIDTH_DEF);
      h      = size_in_use(height_reg, tls_pkg::MAX_HEIGHT_DEF);
      closed = 1'b0;
      box    = '0;

      // lanes of this item that fall inside the row
      if (col_pos >= w) lanes_in = 0;
      else if (w - col_pos >= LANE_COUNT) lanes_in = LANE_COUNT;
      else lanes_in = w - col_pos;

      for (i = 0; i < lanes_in; i++) begin
         if (ink[i]) begin
            if (!row_inked) begin
               row_inked = 1'b1;
               row_left  = tls_pkg::COORD_W'(col_pos + i);
            end
            row_right = tls_pkg::COORD_W'(col_pos + i);
         end
      end

      if (col_pos + LANE_COUNT < w) begin
         col_pos += LANE_COUNT;
         return 1'b0;
      end

      // row done: extend, open or close the line
      if (row_inked) begin
         if (!in_line) begin
            in_line    = 1'b1;
            line_top   = tls_pkg::COORD_W'(row_pos);
            line_left  = row_left;
            line_right = row_right;
         end else begin
            if (row_left < line_left) line_left = row_left;
            if (row_right > line_right) line_right = row_right;
         end
      end else if (in_line) begin
         box     = box_of(line_left, line_top, line_right,
                          tls_pkg::COORD_W'(row_pos - 1), 1'b0);
         in_line = 1'b0;
         closed  = 1'b1;
      end

      col_pos   = 0;
      row_inked = 1'b0;
      row_left  = '0;
      row_right = '0;

      // frame end closes whatever is still open
      if (row_pos + 1 >= h) begin
         if (in_line) begin
            box    = box_of(line_left, line_top, line_right,
                            tls_pkg::COORD_W'(row_pos), 1'b1);
            closed = 1'b1;
         end
         in_line = 1'b0;
         row_pos = 0;
      end else begin
         row_pos++;
      end
      return closed;
   endfunction

   task automatic step_csr(input logic [tls_pkg::CSR_INDEX_W-1:0] index,
                           input logic [tls_pkg::CFG_W-1:0] data);
      plan_step_type s;
      s       = '0;
      s.kind  = STEP_CSR;
      s.index = index;
      s.data  = data;
      directed_plan.push_back(s);
   endtask

   task automatic step_item(input step_kind_type kind, input logic [7:0] ink,
                            input tls_pkg::box_type box);
      plan_step_type s;
      s      = '0;
      s.kind = kind;
      s.ink  = ink;
      s.box  = box;
      directed_plan.push_back(s);
   endtask

   // offer one item, with random idle cycles first; returns at acceptance
   task automatic send_item(input logic [LANE_COUNT-1:0] ink);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_ink_bits <= ink;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [tls_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [tls_pkg::CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == tls_pkg::CSR_IMAGE_WIDTH) width_reg = value;
      else if (index == tls_pkg::CSR_IMAGE_HEIGHT) height_reg = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every queued box, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (line_box_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (pressure_req && !pressure_done) begin
         hold_left     = PRESSURE_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // compare each accepted box with the oldest one queued
   always @(posedge clock) begin : box_checker
      tls_pkg::box_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_box_q.size() == 0) begin
            $display("%0t: unexpected box, expected none, got l=%0d t=%0d r=%0d b=%0d e=%0d",
                     $time, rsp_left, rsp_top, rsp_right, rsp_bottom, rsp_at_frame_end);
            error_count++;
         end else begin
            want = line_box_q.pop_front();
            if (rsp_left !== want.left) begin
               $display("%0t: left expected %0d, got %0d", $time, want.left, rsp_left);
               error_count++;
            end
            if (rsp_top !== want.top) begin
               $display("%0t: top expected %0d, got %0d", $time, want.top, rsp_top);
               error_count++;
            end
            if (rsp_right !== want.right) begin
               $display("%0t: right expected %0d, got %0d", $time, want.right, rsp_right);
               error_count++;
            end
            if (rsp_bottom !== want.bottom) begin
               $display("%0t: bottom expected %0d, got %0d", $time, want.bottom, rsp_bottom);
               error_count++;
            end
            if (rsp_at_frame_end !== want.at_frame_end) begin
               $display("%0t: at_frame_end expected %0d, got %0d",
                        $time, want.at_frame_end, rsp_at_frame_end);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      tls_pkg::box_type pred_box;
      tls_pkg::box_type none;
      bit               produced;
      int               p;
      int               n;
      int unsigned      pick;
      logic [7:0]       ink;
      none = '0;

      // zero sizes act as one: every item is a row and a frame
      step_csr(tls_pkg::CSR_IMAGE_WIDTH, 13'd0);
      step_csr(tls_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      step_item(STEP_BOX, 8'h01, box_of(0, 0, 0, 0, 1'b1));
      step_item(STEP_PREDICT, 8'hFE, none);      // lanes past the width ignored
      // two-group rows, four-row frame
      step_csr(tls_pkg::CSR_IMAGE_WIDTH, 13'd16);
      step_csr(tls_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      step_item(STEP_PREDICT, 8'h00, none);
      step_item(STEP_PREDICT, 8'h80, none);
      step_item(STEP_PREDICT, 8'h01, none);
      step_item(STEP_PREDICT, 8'h00, none);
      step_item(STEP_PREDICT, 8'h00, none);
      step_item(STEP_BOX, 8'h00, box_of(0, 0, 15, 1, 1'b0));    // blank row closes
      step_item(STEP_PREDICT, 8'hFF, none);
      step_item(STEP_BOX, 8'hFF, box_of(0, 3, 15, 3, 1'b1));    // frame end closes
      // partial last group
      step_csr(tls_pkg::CSR_IMAGE_WIDTH, 13'd12);
      step_csr(tls_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      step_item(STEP_PREDICT, 8'h00, none);
      step_item(STEP_PREDICT, 8'hF0, none);
      step_item(STEP_PREDICT, 8'h00, none);
      step_item(STEP_BOX, 8'h08, box_of(11, 1, 11, 1, 1'b1));
      // width shrinks mid-row: next group is past the row and ends it
      step_item(STEP_PREDICT, 8'h02, none);
      step_csr(tls_pkg::CSR_IMAGE_WIDTH, 13'd8);
      step_item(STEP_PREDICT, 8'hFF, none);
      step_item(STEP_BOX, 8'h00, box_of(1, 0, 1, 0, 1'b0));
      // height shrinks mid-frame; blank row at frame end gives one box only
      step_item(STEP_PREDICT, 8'h40, none);
      step_csr(tls_pkg::CSR_IMAGE_HEIGHT, 13'd1);
      step_item(STEP_BOX, 8'h00, box_of(6, 0, 6, 0, 1'b0));
      // spare indexes change nothing
      step_csr(CSR_SPARE_2, 13'd5);
      step_csr(CSR_SPARE_3, 13'h1FFF);
      step_item(STEP_BOX, 8'h01, box_of(0, 0, 0, 0, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_plan[k]) begin
         if (directed_plan[k].kind == STEP_CSR) begin
            settle_block();
            write_register(directed_plan[k].index, directed_plan[k].data);
         end else begin
            send_item(directed_plan[k].ink);
            produced = fold_group(directed_plan[k].ink, pred_box);
            if (directed_plan[k].kind == STEP_BOX) line_box_q.push_back(directed_plan[k].box);
            else if (produced) line_box_q.push_back(pred_box);
         end
      end

      // random frames
      for (p = 0; p < PHASES; p++) begin
         settle_block();
         write_register(tls_pkg::CSR_IMAGE_WIDTH, tls_pkg::CFG_W'(phase_width[p]));
         write_register(tls_pkg::CSR_IMAGE_HEIGHT, tls_pkg::CFG_W'(phase_height[p]));
         sender_idle_pct = phase_idle[p];
         rsp_stall_pct   = phase_stall[p];
         if (p == 0) pressure_req = 1'b1;
         for (n = 0; n < phase_items[p]; n++) begin
            // pick a style per row so inked and blank rows form runs
            if (col_pos == 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 4) row_style = ROW_BLANK;
               else if (pick < 8) row_style = ROW_SPARSE;
               else row_style = ROW_DENSE;
            end
            if ($urandom_range(0, 19) == 0) ink = 8'($urandom);
            else if (row_style == ROW_BLANK) ink = 8'h00;
            else if (row_style == ROW_SPARSE)
               ink = ($urandom_range(0, 5) == 0) ? (8'h01 << $urandom_range(0, 7)) : 8'h00;
            else ink = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
            send_item(ink);
            if (fold_group(ink, pred_box)) line_box_q.push_back(pred_box);
         end
      end

      settle_block();
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
